// ===== src/fpsqrt_pkg.sv =====
package fpsqrt_pkg;

    // Field widths
    localparam int ARG_W  = 32;
    localparam int ROOT_W = 24;

    // One root bit per cell
    localparam int STEPS  = ROOT_W;

    // Partial remainder stays below 2 * root + 2, so two bits over the root
    localparam int REM_W  = ROOT_W + 2;

    // Bytes of the output tdata word
    localparam int OUT_BYTES = (ROOT_W + 7) / 8;

    // Data that one cell hands to the next
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [ARG_W-1:0]  arg;
    } cell_data_t;

endpackage

// ===== src/fpsqrt_cell.sv =====
module fpsqrt_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   in_valid,
    input  fpsqrt_pkg::cell_data_t in_data,
    output logic                   out_valid,
    output fpsqrt_pkg::cell_data_t out_data
);

    logic                            valid_reg;
    fpsqrt_pkg::cell_data_t          data_reg;
    fpsqrt_pkg::cell_data_t          data_next;
    logic [fpsqrt_pkg::REM_W+1:0]    rem_shift;
    logic [fpsqrt_pkg::ROOT_W+1:0]   trial;
    logic [fpsqrt_pkg::REM_W+2:0]    diff;
    logic                            fits;

    // Bring in the next two argument bits and test against twice the shifted root plus one
    always_comb
    begin
        rem_shift = {in_data.rem, in_data.arg[fpsqrt_pkg::ARG_W-1 -: 2]};
        trial     = {in_data.root, 2'b01};
        diff      = {1'b0, rem_shift}
                    - {{(fpsqrt_pkg::REM_W + 1 - fpsqrt_pkg::ROOT_W){1'b0}}, trial};
        fits      = !diff[fpsqrt_pkg::REM_W+2];

        data_next.rem  = fits ? diff[fpsqrt_pkg::REM_W-1:0]
                              : rem_shift[fpsqrt_pkg::REM_W-1:0];
        data_next.root = {in_data.root[fpsqrt_pkg::ROOT_W-2:0], fits};
        data_next.arg  = {in_data.arg[fpsqrt_pkg::ARG_W-3:0], 2'b00};
    end

    // Advance the valid flag with the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload; hold it while the chain is stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/fixed_point_square_root.sv =====
// Fixed-point square root, 16.16 in, 8.16 out.
//
// Input channel (s_*): one transaction carries a 32-bit unsigned radicand in
// 16.16 format. Output channel (m_*): one transaction carries the 24-bit root,
// floor(sqrt(radicand * 2^16)), filling all 24 bits of tdata.
//
// The root is built by a chain of 24 identical cells, one root bit per cell,
// each cell folding two argument bits into the partial remainder. The last
// cell is the output register.
//
// Throughput: one transaction per cycle while the receiver takes results.
//
// Stall: when m_tvalid is high and m_tready is low, the whole chain holds and
// s_tready drops; no result is lost or repeated. Empty cells further up do not
// let the chain move; s_tready is high whenever the output is empty or taken.
//
// Reset: rst_n clears every cell valid flag; the chain is empty and ready
// right after reset is released. No state is kept between transactions.
module fixed_point_square_root (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fpsqrt_pkg::ARG_W-1:0]   s_tdata,   // [31:0] radicand
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [8*fpsqrt_pkg::OUT_BYTES-1:0] m_tdata // [23:0] root
);

    logic                   advance;
    logic [fpsqrt_pkg::STEPS:0]   valid_chain;
    fpsqrt_pkg::cell_data_t data_chain [fpsqrt_pkg::STEPS+1];

    // Move the chain whenever the output slot is empty or being taken
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // Feed the first cell straight from the input
    assign valid_chain[0]     = s_tvalid;
    assign data_chain[0].rem  = '0;
    assign data_chain[0].root = '0;
    assign data_chain[0].arg  = s_tdata;

    // Row of root cells
    for (genvar k = 0; k < fpsqrt_pkg::STEPS; k++)
    begin : g_cell
        fpsqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (valid_chain[k]),
            .in_data   (data_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_data  (data_chain[k+1])
        );
    end

    // Last cell is the output register
    assign m_tvalid = valid_chain[fpsqrt_pkg::STEPS];
    assign m_tdata  = data_chain[fpsqrt_pkg::STEPS].root;

    // An accepted transaction lands in the first cell
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_chain[1])
        else $error("accepted transaction did not enter the first cell");

    // A stalled output freezes every cell flag
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(valid_chain[fpsqrt_pkg::STEPS:1]))
        else $error("cell chain moved during an output stall");

    // A taken output with a full next-to-last cell is refilled at once
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && valid_chain[fpsqrt_pkg::STEPS-1]) |=> m_tvalid)
        else $error("output slot not refilled from the chain");

    // A stalled output blocks new input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the output stalls");

endmodule

// ===== test/tb_fixed_point_square_root.sv =====
module tb_fixed_point_square_root;

    localparam int OUT_W      = 8 * fpsqrt_pkg::OUT_BYTES;
    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM   = 1000;
    localparam int MAX_REPORT = 10;

    // One row of the directed table: the expected root is typed in only when known is set
    typedef struct packed {
        logic [fpsqrt_pkg::ARG_W-1:0]  radicand;
        logic                          known;
        logic [fpsqrt_pkg::ROOT_W-1:0] root;
    } stim_row_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [fpsqrt_pkg::ARG_W-1:0]  s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [OUT_W-1:0]              m_tdata;

    // Roots still owed by the block, oldest first
    logic [fpsqrt_pkg::ROOT_W-1:0] pending_roots[$];
    int                error_count = 0;
    bit                quiet       = 1'b0;

    stim_row_t directed_rows[0:N_DIRECTED-1] = '{
        '{32'h0000_0000, 1'b1, 24'h00_0000},   // zero argument
        '{32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF},   // largest argument
        '{32'h0000_0001, 1'b1, 24'h00_0100},   // smallest nonzero
        '{32'h0000_0004, 1'b1, 24'h00_0200},
        '{32'h0001_0000, 1'b1, 24'h01_0000},   // 1.0
        '{32'h0004_0000, 1'b1, 24'h02_0000},   // 4.0
        '{32'h0009_0000, 1'b1, 24'h03_0000},   // 9.0
        '{32'h0000_0002, 1'b0, 24'h00_0000},
        '{32'h0000_0003, 1'b0, 24'h00_0000},
        '{32'h0002_0000, 1'b0, 24'h00_0000},   // 2.0
        '{32'h8000_0000, 1'b0, 24'h00_0000},
        '{32'h7FFF_FFFF, 1'b0, 24'h00_0000},
        '{32'h5555_5555, 1'b0, 24'h00_0000},
        '{32'hAAAA_AAAA, 1'b0, 24'h00_0000},
        '{32'hFFFF_0000, 1'b0, 24'h00_0000},
        '{32'h0000_FFFF, 1'b0, 24'h00_0000},
        '{32'hFFFE_0001, 1'b0, 24'h00_0000},
        '{32'hFFFF_FFFE, 1'b0, 24'h00_0000},
        '{32'h1234_5678, 1'b0, 24'h00_0000},
        '{32'h0000_0000, 1'b1, 24'h00_0000}    // zero again after the largest values
    };

    fixed_point_square_root uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Restoring digit-by-digit root of radicand * 2^16, two argument bits per step
    function automatic logic [fpsqrt_pkg::ROOT_W-1:0] calc_root(
        input logic [fpsqrt_pkg::ARG_W-1:0] radicand);
        logic [63:0] scaled;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        int          i;
        scaled = {16'd0, radicand, 16'd0};
        rem    = '0;
        root   = '0;
        for (i = fpsqrt_pkg::STEPS - 1; i >= 0; i--)
        begin
            rem   = (rem << 2) | ((scaled >> (2 * i)) & 64'd3);
            root  = root << 1;
            trial = (root << 1) + 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = root + 64'd1;
            end
        end
        return root[fpsqrt_pkg::ROOT_W-1:0];
    endfunction

    task automatic flag_error(input string msg);
        if (error_count < MAX_REPORT)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Offer one radicand, idling at random first, and log its root once the transaction completes
    task automatic send_radicand(input logic [fpsqrt_pkg::ARG_W-1:0] value,
                                 input logic [fpsqrt_pkg::ROOT_W-1:0] root);
        while (!quiet && $urandom_range(99) < 36)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_roots.push_back(root);
    endtask

    // Hold the input idle until every owed root has come out
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: stall at random, check each result transaction against the oldest owed root
    always @(posedge clk)
    begin : result_check
        logic [fpsqrt_pkg::ROOT_W-1:0] want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= quiet || ($urandom_range(99) >= 36);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_roots.size() == 0)
                flag_error($sformatf("unexpected result tdata=%h", m_tdata));
            else
            begin
                want = pending_roots.pop_front();
                if (m_tdata !== OUT_W'(want))
                    flag_error($sformatf("root mismatch: expected %h, got %h", want, m_tdata));
            end
        end
    end

    initial
    begin
        int                            i;
        int                            pick;
        logic [fpsqrt_pkg::ARG_W-1:0]  value;
        logic [fpsqrt_pkg::ROOT_W-1:0] r;
        logic [47:0]                   sq;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (i = 0; i < N_DIRECTED; i++)
            send_radicand(directed_rows[i].radicand,
                          directed_rows[i].known ? directed_rows[i].root
                                                 : calc_root(directed_rows[i].radicand));
        drain();

        // Random mix: full range, small values, near squares, near the top, single bits
        for (i = 0; i < N_RANDOM; i++)
        begin
            quiet = (i >= 250 && i < 450);
            if (i == 600)
                drain();
            pick = $urandom_range(99);
            if (pick < 45)
                value = $urandom();
            else if (pick < 60)
                value = $urandom_range(65535);
            else if (pick < 75)
            begin
                r     = fpsqrt_pkg::ROOT_W'($urandom_range(24'hFF_FFFF));
                sq    = {24'd0, r} * {24'd0, r};
                value = sq[47:16] + $urandom_range(2) - 1;
            end
            else if (pick < 85)
                value = 32'hFFFF_FFFF - $urandom_range(255);
            else
                value = 32'h1 << $urandom_range(31);
            send_radicand(value, calc_root(value));
        end
        quiet = 1'b0;

        // Let the chain empty, then watch for stray results
        drain();
        repeat (2 * fpsqrt_pkg::STEPS + 8) @(posedge clk);
        if (pending_roots.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_roots.size()));

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== fixed_point_square_root.f =====
src/fpsqrt_pkg.sv
src/fpsqrt_cell.sv
src/fixed_point_square_root.sv
test/tb_fixed_point_square_root.sv
